// ===== rtl/php_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet header parser package
// Beat and result types, header constants and protocol codes shared by the
// parser modules.
// ----------------------------------------------------------------------------
package php_pkg;

   // Ethertypes and IP protocol numbers.
   localparam logic [15:0] ETYPE_VLAN  = 16'h8100;
   localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
   localparam logic [15:0] ETYPE_IPV6  = 16'h86DD;
   localparam logic [7:0]  PROTO_ICMP  = 8'd1;
   localparam logic [7:0]  PROTO_UDP   = 8'd17;
   localparam logic [7:0]  PROTO_TCP   = 8'd6;

   // Byte offsets inside the Ethernet header and tag.
   localparam int ETH_TYPE_OFS  = 12;
   localparam int VLAN_TYPE_OFS = 16;
   localparam int ETH_HDR_BYTES = 14;
   localparam int VLAN_HDR_BYTES = 18;

   // Byte offsets relative to the start of the IP header.
   localparam int IPV4_PROTO_OFS = 9;
   localparam int IPV4_SRC_OFS   = 12;
   localparam int IPV4_DST_OFS   = 16;
   localparam int IPV4_MIN_BYTES = 20;
   localparam int IPV6_NEXT_OFS  = 6;
   localparam int IPV6_SRC_OFS   = 8;
   localparam int IPV6_HDR_BYTES = 40;

   // Transport header sizes and the span holding the port pair.
   localparam int L4_SHORT_BYTES = 8;
   localparam int TCP_HDR_BYTES  = 20;
   localparam int PORT_BYTES     = 4;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TOO_SHORT = 2'd1,
      ST_UNKNOWN   = 2'd2,
      ST_BAD_HDR   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      L3_NONE = 2'd0,
      L3_IPV4 = 2'd1,
      L3_IPV6 = 2'd2
   } l3_kind_type;

   typedef enum logic [1:0] {
      L4_NONE = 2'd0,
      L4_ICMP = 2'd1,
      L4_UDP  = 2'd2,
      L4_TCP  = 2'd3
   } l4_kind_type;

   // One input beat.
   typedef struct packed {
      logic [7:0] packet_byte;
      logic       last_byte;
   } req_type;

   // One result beat.
   typedef struct packed {
      status_type  parse_status;
      l3_kind_type l3_kind;
      l4_kind_type l4_kind;
      logic        vlan_tagged;
      logic [63:0] source_high;
      logic [63:0] source_low;
      logic [63:0] dest_high;
      logic [63:0] dest_low;
      logic [15:0] source_port;
      logic [15:0] dest_port;
   } rsp_type;

   // Header fields collected so far for the current frame.
   typedef struct packed {
      logic [15:0] ethertype;
      logic        tag_seen;
      l3_kind_type network_kind;
      logic [5:0]  ip_header_bytes;
      logic [7:0]  protocol;
      l4_kind_type transport_kind;
      logic [63:0] src_high;
      logic [63:0] src_low;
      logic [63:0] dst_high;
      logic [63:0] dst_low;
      logic [15:0] src_port;
      logic [15:0] dst_port;
   } php_state_type;

   // Maps an IP protocol number to the transport kind.
   function automatic l4_kind_type proto_kind(input logic [7:0] proto);
      l4_kind_type kind;
      case (proto)
         PROTO_ICMP: kind = L4_ICMP;
         PROTO_UDP:  kind = L4_UDP;
         PROTO_TCP:  kind = L4_TCP;
         default:    kind = L4_NONE;
      endcase
      return kind;
   endfunction

endpackage

// ===== rtl/php_capture.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet header parser field capture
// Holds the byte position and the header fields of the current frame and
// shifts each accepted byte into the field that owns its offset.
// ----------------------------------------------------------------------------
module php_capture
   import php_pkg::*;
#(
   parameter int POSITION_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     beat_accept,
   input  req_type                  beat,
   output logic [POSITION_BITS-1:0] position,
   output php_state_type            captured
);

   localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;
   localparam logic [POSITION_BITS-1:0] P_TYPE_HI = POSITION_BITS'(ETH_TYPE_OFS);
   localparam logic [POSITION_BITS-1:0] P_TYPE_LO = POSITION_BITS'(ETH_TYPE_OFS + 1);
   localparam logic [POSITION_BITS-1:0] P_VTYPE_HI = POSITION_BITS'(VLAN_TYPE_OFS);
   localparam logic [POSITION_BITS-1:0] P_VTYPE_LO = POSITION_BITS'(VLAN_TYPE_OFS + 1);
   localparam logic [POSITION_BITS-1:0] P_ETH_L3  = POSITION_BITS'(ETH_HDR_BYTES);
   localparam logic [POSITION_BITS-1:0] P_VLAN_L3 = POSITION_BITS'(VLAN_HDR_BYTES);
   localparam logic [POSITION_BITS-1:0] R_V4_PROTO = POSITION_BITS'(IPV4_PROTO_OFS);
   localparam logic [POSITION_BITS-1:0] R_V4_SRC  = POSITION_BITS'(IPV4_SRC_OFS);
   localparam logic [POSITION_BITS-1:0] R_V4_DST  = POSITION_BITS'(IPV4_DST_OFS);
   localparam logic [POSITION_BITS-1:0] R_V4_END  = POSITION_BITS'(IPV4_MIN_BYTES);
   localparam logic [POSITION_BITS-1:0] R_V6_NEXT = POSITION_BITS'(IPV6_NEXT_OFS);
   localparam logic [POSITION_BITS-1:0] R_V6_SRC  = POSITION_BITS'(IPV6_SRC_OFS);
   localparam logic [POSITION_BITS-1:0] R_V6_END  = POSITION_BITS'(IPV6_HDR_BYTES);
   localparam logic [POSITION_BITS-1:0] Q_PORTS   = POSITION_BITS'(PORT_BYTES);
   localparam logic [5:0]               IHB_MIN   = 6'(IPV4_MIN_BYTES);
   localparam logic [5:0]               IHB_V6    = 6'(IPV6_HDR_BYTES);

   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   php_state_type            st_ff, st_in;
   php_state_type            cap;
   logic [7:0]               b;
   logic [POSITION_BITS-1:0] l3_ofs;
   logic [POSITION_BITS-1:0] l4_ofs;
   logic [POSITION_BITS-1:0] r;
   logic [POSITION_BITS-1:0] r6;
   logic [POSITION_BITS-1:0] q;

   assign b        = beat.packet_byte;
   assign position = pos_ff;
   assign captured = cap;

   // Header field capture for the byte at the current position.
   always_comb begin
      cap    = st_ff;
      l3_ofs = st_ff.tag_seen ? P_VLAN_L3 : P_ETH_L3;
      r      = pos_ff - l3_ofs;
      r6     = r - R_V6_SRC;
      l4_ofs = '0;
      q      = '0;
      if (pos_ff != POS_MAX) begin
         // Ethertype: outer one, then the inner one behind a tag.
         if (pos_ff == P_TYPE_HI || pos_ff == P_TYPE_LO ||
             (st_ff.tag_seen && (pos_ff == P_VTYPE_HI || pos_ff == P_VTYPE_LO))) begin
            cap.ethertype = {cap.ethertype[7:0], b};
         end
         if (pos_ff == P_TYPE_LO && cap.ethertype == ETYPE_VLAN) begin
            cap.tag_seen = 1'b1;
         end
         if (pos_ff >= l3_ofs) begin
            // First IP byte decides the network kind.
            if (r == '0) begin
               if (cap.ethertype == ETYPE_IPV4) begin
                  cap.network_kind    = L3_IPV4;
                  cap.ip_header_bytes = {b[3:0], 2'b00};
               end else if (cap.ethertype == ETYPE_IPV6) begin
                  cap.network_kind    = L3_IPV6;
                  cap.ip_header_bytes = IHB_V6;
               end else begin
                  cap.network_kind = L3_NONE;
               end
            end
            // Protocol and address bytes.
            if (cap.network_kind == L3_IPV4) begin
               if (r == R_V4_PROTO) begin
                  cap.protocol = b;
               end
               if (r >= R_V4_SRC && r < R_V4_DST) begin
                  cap.src_low = {32'd0, cap.src_low[23:0], b};
               end
               if (r >= R_V4_DST && r < R_V4_END) begin
                  cap.dst_low = {32'd0, cap.dst_low[23:0], b};
               end
            end else if (cap.network_kind == L3_IPV6) begin
               if (r == R_V6_NEXT) begin
                  cap.protocol = b;
               end
               if (r >= R_V6_SRC && r < R_V6_END) begin
                  case (r6[4:3])
                     2'd0:    cap.src_high = {cap.src_high[55:0], b};
                     2'd1:    cap.src_low  = {cap.src_low[55:0], b};
                     2'd2:    cap.dst_high = {cap.dst_high[55:0], b};
                     default: cap.dst_low  = {cap.dst_low[55:0], b};
                  endcase
               end
            end
            // Transport header: kind on its first byte, then the ports.
            if (cap.network_kind != L3_NONE && cap.ip_header_bytes >= IHB_MIN) begin
               l4_ofs = l3_ofs + POSITION_BITS'(cap.ip_header_bytes);
               q      = pos_ff - l4_ofs;
               if (pos_ff >= l4_ofs) begin
                  if (q == '0) begin
                     cap.transport_kind = proto_kind(cap.protocol);
                  end
                  if ((cap.transport_kind == L4_UDP || cap.transport_kind == L4_TCP) &&
                      q < Q_PORTS) begin
                     if (q[1] == 1'b0) begin
                        cap.src_port = {cap.src_port[7:0], b};
                     end else begin
                        cap.dst_port = {cap.dst_port[7:0], b};
                     end
                  end
               end
            end
         end
      end
   end

   // Next frame state: cleared after the last beat of a frame.
   always_comb begin
      st_in  = st_ff;
      pos_in = pos_ff;
      if (beat_accept) begin
         if (beat.last_byte) begin
            st_in  = '0;
            pos_in = '0;
         end else begin
            st_in = cap;
            if (pos_ff != POS_MAX) begin
               pos_in = pos_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= '0;
         pos_ff <= '0;
      end else begin
         st_ff  <= st_in;
         pos_ff <= pos_in;
      end
   end

endmodule

// ===== rtl/php_finish.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet header parser result builder
// Checks the frame length against each header in turn and assembles the
// status, kinds, addresses and ports of the frame that ends on this beat.
// ----------------------------------------------------------------------------
module php_finish
   import php_pkg::*;
#(
   parameter int POSITION_BITS = 8
) (
   input  logic [POSITION_BITS-1:0] position,
   input  php_state_type            captured,
   output rsp_type                  result
);

   localparam int NW = POSITION_BITS + 1;

   logic [NW-1:0] n;
   logic [NW-1:0] l3_ofs;
   logic [NW-1:0] ip_end;
   logic [NW-1:0] l4_end;
   logic          is_v4;
   logic          is_v6;
   l4_kind_type   kind;

   // Frame length and the end of each header.
   always_comb begin
      n      = {1'b0, position} + NW'(1);
      l3_ofs = captured.tag_seen ? NW'(VLAN_HDR_BYTES) : NW'(ETH_HDR_BYTES);
      is_v4  = (captured.ethertype == ETYPE_IPV4);
      is_v6  = (captured.ethertype == ETYPE_IPV6);
      kind   = proto_kind(captured.protocol);
      ip_end = l3_ofs + (is_v6 ? NW'(IPV6_HDR_BYTES) : NW'(IPV4_MIN_BYTES));
      l4_end = l3_ofs + NW'(captured.ip_header_bytes) +
               ((kind == L4_TCP) ? NW'(TCP_HDR_BYTES) : NW'(L4_SHORT_BYTES));
   end

   // Status decision, one header at a time.
   always_comb begin
      result             = '0;
      result.vlan_tagged = captured.tag_seen;
      // The L3 offset is at least the Ethernet header length, so one compare
      // covers both a short Ethernet header and a short tag.
      if (n < l3_ofs) begin
         result.parse_status = ST_TOO_SHORT;
      end else if (!is_v4 && !is_v6) begin
         result.parse_status = ST_UNKNOWN;
      end else if (n < ip_end) begin
         result.parse_status = ST_TOO_SHORT;
      end else begin
         result.l3_kind     = captured.network_kind;
         result.source_high = captured.src_high;
         result.source_low  = captured.src_low;
         result.dest_high   = captured.dst_high;
         result.dest_low    = captured.dst_low;
         if (captured.ip_header_bytes < 6'(IPV4_MIN_BYTES)) begin
            result.parse_status = ST_BAD_HDR;
         end else if (kind == L4_NONE) begin
            result.parse_status = ST_UNKNOWN;
         end else if (n < l4_end) begin
            result.parse_status = ST_TOO_SHORT;
         end else begin
            result.parse_status = ST_OK;
            result.l4_kind      = kind;
            if (kind == L4_UDP || kind == L4_TCP) begin
               result.source_port = captured.src_port;
               result.dest_port   = captured.dst_port;
            end
         end
      end
   end

endmodule

// ===== rtl/php_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet header parser result buffer
// Result register with one skid slot, so a new result can be taken while
// the previous one is still stalled at the output.
// ----------------------------------------------------------------------------
module php_out_buf
   import php_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    take;

   assign take      = main_valid_ff && !rsp_stall;
   assign full      = main_valid_ff && skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   // Slot bookkeeping. A push never arrives while both slots are full.
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in       = push_data;
         end
      end else if (push) begin
         if (main_valid_ff) begin
            skid_valid_in = 1'b1;
            skid_in       = push_data;
         end else begin
            main_valid_in = 1'b1;
            main_in       = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

// ===== rtl/packet_header_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet header parser
// Parses Ethernet, one optional 802.1Q tag, IPv4 or IPv6, and ICMP, UDP or
// TCP headers from a byte stream and gives one result beat per frame.
// ----------------------------------------------------------------------------
// The parser takes one frame byte per cycle, one beat per cycle with no gaps
// of its own while req_stall is low, and gives one result beat for the beat
// marked last. That result is presented in the cycle after the beat is
// accepted, unless an earlier result is still waiting at a stalled output, in
// which case it follows that one. Each byte updates the position counter and
// the header registers; the result is built from those registers and the
// last byte and loaded into a result register. A skid slot behind the result
// register holds one more result, so req_stall rises only when two finished
// results are both waiting at a stalled output.
module packet_header_parser
   import php_pkg::*;
#(
   parameter int POSITION_BITS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic                     beat_accept;
   logic                     push;
   logic                     buf_full;
   logic [POSITION_BITS-1:0] position;
   php_state_type            captured;
   rsp_type                  result;

   // Input handshake.
   assign req_stall   = buf_full;
   assign beat_accept = req_valid && !req_stall;
   assign push        = beat_accept && req_data.last_byte;

   php_capture #(
      .POSITION_BITS (POSITION_BITS)
   ) u_capture (
      .clock       (clock),
      .reset       (reset),
      .beat_accept (beat_accept),
      .beat        (req_data),
      .position    (position),
      .captured    (captured)
   );

   php_finish #(
      .POSITION_BITS (POSITION_BITS)
   ) u_finish (
      .position (position),
      .captured (captured),
      .result   (result)
   );

   php_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // A last beat always leaves a result at the output in the next cycle.
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      push |=> rsp_valid)
      else $error("last beat accepted but no result presented");

   // The next frame starts at position zero.
   a_position_restarts: assert property (@(posedge clock) disable iff (reset)
      push |=> (position == '0))
      else $error("byte position not cleared after last beat");

   // Input is held back only while a result is waiting.
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   // A clean parse always names both a network and a transport header.
   a_ok_has_kinds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.parse_status == ST_OK) |->
         (rsp_data.l3_kind != L3_NONE && rsp_data.l4_kind != L4_NONE))
      else $error("ok status without protocol kinds");
`endif

endmodule

// ===== dv/tb_packet_header_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet header parser testbench
// Streams Ethernet frames into the parser one byte beat at a time. A
// behavioral copy of the header parsing state builds the header record for
// every frame, and each result beat is compared field by field. Both sides of
// the block idle and stall at random.
// ----------------------------------------------------------------------------
module tb_packet_header_parser;
   import php_pkg::*;

   localparam int          POSITION_BITS     = 8;
   localparam int unsigned POS_LIMIT         = (1 << POSITION_BITS) - 1;
   localparam int          TOTAL_BEATS       = 1950;
   localparam int          RUN_LIMIT         = 500_000;
   localparam int          DRAIN_CYCLES      = 20;

   // Byte fill patterns for the generated header bytes.
   localparam int FILL_RANDOM = 0;
   localparam int FILL_ZERO   = 1;
   localparam int FILL_ONES   = 2;

   // Codes that the parser does not know.
   localparam logic [15:0] ETYPE_LLDP   = 16'h88CC;
   localparam logic [7:0]  PROTO_GRE    = 8'd47;
   localparam logic [7:0]  PROTO_ICMPV6 = 8'd58;

   // Header fields collected for the frame in flight.
   typedef struct packed {
      logic [15:0] position;
      logic [15:0] ethertype;
      logic        vlan_seen;
      l3_kind_type l3;
      logic [5:0]  ip_len;
      logic [7:0]  proto;
      l4_kind_type l4;
      logic [63:0] src_hi;
      logic [63:0] src_lo;
      logic [63:0] dst_hi;
      logic [63:0] dst_lo;
      logic [15:0] src_port;
      logic [15:0] dst_port;
   } parse_track_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   parse_track_type frame_track  = '0;
   req_type         outgoing_beats [$];
   rsp_type         parsed_headers [$];
   logic [7:0]      frame_bytes [$];
   int              beats_total   = 0;
   int              beats_taken   = 0;
   int              header_errors = 0;
   int              cycle_count   = 0;
   int              req_gap       = 0;
   int              req_calm      = 0;
   int              rsp_wait      = 0;
   int              rsp_calm      = 0;

   packet_header_parser #(
      .POSITION_BITS(POSITION_BITS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #10 clock = ~clock;

   // Idle cycles before the next beat; runs of back-to-back beats now and then.
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0)
         calm = $urandom_range(20, 80);
      return $urandom_range(0, 19);
   endfunction

   function automatic l4_kind_type kind_for_proto(input logic [7:0] proto);
      if (proto == PROTO_ICMP) return L4_ICMP;
      if (proto == PROTO_UDP)  return L4_UDP;
      if (proto == PROTO_TCP)  return L4_TCP;
      return L4_NONE;
   endfunction

   function automatic logic [7:0] pick_byte(input int pattern);
      case (pattern)
         FILL_ZERO: return 8'h00;
         FILL_ONES: return 8'hFF;
         default:   return 8'($urandom);
      endcase
   endfunction

   // Folds one accepted byte into the header state; on the last byte of a
   // frame the header record is built and the state starts over.
   task automatic parse_byte(input req_type beat);
      rsp_type     hdr;
      logic [7:0]  b;
      int unsigned p, l3_ofs, r, q, l4_ofs, n, ip_need, l4_need;
      l4_kind_type k;
      b = beat.packet_byte;
      p = frame_track.position;
      l3_ofs = frame_track.vlan_seen ? VLAN_HDR_BYTES : ETH_HDR_BYTES;
      if (p < POS_LIMIT) begin
         if (p == 12 || p == 13 || (frame_track.vlan_seen && (p == 16 || p == 17)))
            frame_track.ethertype = {frame_track.ethertype[7:0], b};
         if (p == 13 && frame_track.ethertype == ETYPE_VLAN)
            frame_track.vlan_seen = 1'b1;
         if (p >= l3_ofs) begin
            r = p - l3_ofs;
            // The first network byte decides the network header kind.
            if (r == 0) begin
               if (frame_track.ethertype == ETYPE_IPV4) begin
                  frame_track.l3 = L3_IPV4;
                  frame_track.ip_len = {b[3:0], 2'b00};
               end else if (frame_track.ethertype == ETYPE_IPV6) begin
                  frame_track.l3 = L3_IPV6;
                  frame_track.ip_len = 6'(IPV6_HDR_BYTES);
               end else begin
                  frame_track.l3 = L3_NONE;
               end
            end
            if (frame_track.l3 == L3_IPV4) begin
               if (r == IPV4_PROTO_OFS)
                  frame_track.proto = b;
               if (r >= IPV4_SRC_OFS && r < IPV4_DST_OFS)
                  frame_track.src_lo = {32'h0, frame_track.src_lo[23:0], b};
               if (r >= IPV4_DST_OFS && r < IPV4_MIN_BYTES)
                  frame_track.dst_lo = {32'h0, frame_track.dst_lo[23:0], b};
            end else if (frame_track.l3 == L3_IPV6) begin
               if (r == IPV6_NEXT_OFS)
                  frame_track.proto = b;
               if (r >= IPV6_SRC_OFS && r < IPV6_HDR_BYTES) begin
                  case ((r - IPV6_SRC_OFS) >> 3)
                     0: frame_track.src_hi = {frame_track.src_hi[55:0], b};
                     1: frame_track.src_lo = {frame_track.src_lo[55:0], b};
                     2: frame_track.dst_hi = {frame_track.dst_hi[55:0], b};
                     default: frame_track.dst_lo = {frame_track.dst_lo[55:0], b};
                  endcase
               end
            end
            // Transport header, only behind a valid network header.
            l4_ofs = l3_ofs + frame_track.ip_len;
            if (frame_track.l3 != L3_NONE && frame_track.ip_len >= IPV4_MIN_BYTES &&
                p >= l4_ofs) begin
               q = p - l4_ofs;
               if (q == 0)
                  frame_track.l4 = kind_for_proto(frame_track.proto);
               if (frame_track.l4 >= L4_UDP && q < PORT_BYTES) begin
                  if (q < 2)
                     frame_track.src_port = {frame_track.src_port[7:0], b};
                  else
                     frame_track.dst_port = {frame_track.dst_port[7:0], b};
               end
            end
         end
      end
      if (beat.last_byte) begin
         n = p + 1;
         hdr = '0;
         hdr.vlan_tagged = frame_track.vlan_seen;
         if (n < l3_ofs) begin
            hdr.parse_status = ST_TOO_SHORT;
         end else if (frame_track.ethertype != ETYPE_IPV4 &&
                      frame_track.ethertype != ETYPE_IPV6) begin
            hdr.parse_status = ST_UNKNOWN;
         end else begin
            ip_need = (frame_track.ethertype == ETYPE_IPV4) ? IPV4_MIN_BYTES : IPV6_HDR_BYTES;
            if (n < l3_ofs + ip_need) begin
               hdr.parse_status = ST_TOO_SHORT;
            end else begin
               hdr.l3_kind     = frame_track.l3;
               hdr.source_high = frame_track.src_hi;
               hdr.source_low  = frame_track.src_lo;
               hdr.dest_high   = frame_track.dst_hi;
               hdr.dest_low    = frame_track.dst_lo;
               k = kind_for_proto(frame_track.proto);
               l4_need = (k == L4_TCP) ? TCP_HDR_BYTES : L4_SHORT_BYTES;
               if (frame_track.ip_len < IPV4_MIN_BYTES) begin
                  hdr.parse_status = ST_BAD_HDR;
               end else if (k == L4_NONE) begin
                  hdr.parse_status = ST_UNKNOWN;
               end else if (n < l3_ofs + frame_track.ip_len + l4_need) begin
                  hdr.parse_status = ST_TOO_SHORT;
               end else begin
                  hdr.l4_kind = k;
                  if (k >= L4_UDP) begin
                     hdr.source_port = frame_track.src_port;
                     hdr.dest_port   = frame_track.dst_port;
                  end
               end
            end
         end
         parsed_headers.push_back(hdr);
         frame_track = '0;
      end else if (frame_track.position < POS_LIMIT) begin
         frame_track.position++;
      end
   endtask

   // Builds a frame in frame_bytes: MACs, tags, ethertype, an IP header and a
   // transport header when the ethertype is IP, then payload bytes.
   task automatic build_frame(input int tags, input logic [15:0] ethertype,
                              input logic [3:0] ihl, input logic [7:0] proto,
                              input int extra, input int pattern);
      int hdr_len;
      int l4_len;
      frame_bytes.delete();
      repeat (12) frame_bytes.push_back(pick_byte(pattern));
      repeat (tags) begin
         frame_bytes.push_back(ETYPE_VLAN[15:8]);
         frame_bytes.push_back(ETYPE_VLAN[7:0]);
         repeat (2) frame_bytes.push_back(pick_byte(pattern));
      end
      frame_bytes.push_back(ethertype[15:8]);
      frame_bytes.push_back(ethertype[7:0]);
      l4_len = (proto == PROTO_TCP) ? TCP_HDR_BYTES : L4_SHORT_BYTES;
      if (ethertype == ETYPE_IPV4) begin
         hdr_len = (ihl < 5) ? IPV4_MIN_BYTES : ihl * 4;
         frame_bytes.push_back({4'h4, ihl});
         repeat (IPV4_PROTO_OFS - 1) frame_bytes.push_back(pick_byte(pattern));
         frame_bytes.push_back(proto);
         repeat (hdr_len - IPV4_PROTO_OFS - 1) frame_bytes.push_back(pick_byte(pattern));
         repeat (l4_len) frame_bytes.push_back(pick_byte(pattern));
      end else if (ethertype == ETYPE_IPV6) begin
         frame_bytes.push_back(8'h60);
         repeat (IPV6_NEXT_OFS - 1) frame_bytes.push_back(pick_byte(pattern));
         frame_bytes.push_back(proto);
         repeat (IPV6_HDR_BYTES - IPV6_NEXT_OFS - 1)
            frame_bytes.push_back(pick_byte(pattern));
         repeat (l4_len) frame_bytes.push_back(pick_byte(pattern));
      end
      repeat (extra) frame_bytes.push_back(pick_byte(pattern));
   endtask

   // Queues the first cut bytes of frame_bytes (all of them for zero) as beats.
   task automatic send_frame(input int cut);
      int count;
      req_type beat;
      count = (cut > 0 && cut < frame_bytes.size()) ? cut : frame_bytes.size();
      for (int i = 0; i < count; i++) begin
         beat.packet_byte = frame_bytes[i];
         beat.last_byte   = (i == count - 1);
         outgoing_beats.push_back(beat);
      end
   endtask

   task automatic compare_header(input rsp_type got);
      rsp_type want;
      if (parsed_headers.size() == 0) begin
         $error("result beat with no finished frame, parse_status %0d", got.parse_status);
         header_errors++;
      end else begin
         want = parsed_headers.pop_front();
         if (got.parse_status !== want.parse_status) begin
            $error("parse_status: expected %0d, got %0d", want.parse_status, got.parse_status);
            header_errors++;
         end
         if (got.l3_kind !== want.l3_kind) begin
            $error("l3_kind: expected %0d, got %0d", want.l3_kind, got.l3_kind);
            header_errors++;
         end
         if (got.l4_kind !== want.l4_kind) begin
            $error("l4_kind: expected %0d, got %0d", want.l4_kind, got.l4_kind);
            header_errors++;
         end
         if (got.vlan_tagged !== want.vlan_tagged) begin
            $error("vlan_tagged: expected %0d, got %0d", want.vlan_tagged, got.vlan_tagged);
            header_errors++;
         end
         if (got.source_high !== want.source_high) begin
            $error("source_high: expected %h, got %h", want.source_high, got.source_high);
            header_errors++;
         end
         if (got.source_low !== want.source_low) begin
            $error("source_low: expected %h, got %h", want.source_low, got.source_low);
            header_errors++;
         end
         if (got.dest_high !== want.dest_high) begin
            $error("dest_high: expected %h, got %h", want.dest_high, got.dest_high);
            header_errors++;
         end
         if (got.dest_low !== want.dest_low) begin
            $error("dest_low: expected %h, got %h", want.dest_low, got.dest_low);
            header_errors++;
         end
         if (got.source_port !== want.source_port) begin
            $error("source_port: expected %h, got %h", want.source_port, got.source_port);
            header_errors++;
         end
         if (got.dest_port !== want.dest_port) begin
            $error("dest_port: expected %h, got %h", want.dest_port, got.dest_port);
            header_errors++;
         end
      end
   endtask

   // Driver: presents queued byte beats, with a random gap after each one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         req_gap   <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_byte(req_data);
            beats_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_valid <= 1'b0;
               req_gap   <= req_gap - 1;
            end else if (outgoing_beats.size() > 0) begin
               req_valid <= 1'b1;
               req_data  <= outgoing_beats.pop_front();
               req_gap   <= draw_wait(req_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted result beat and then stalls for a while.
   always @(posedge clock) begin
      int next_wait;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait  <= 0;
      end else begin
         next_wait = rsp_wait;
         if (rsp_valid && !rsp_stall) begin
            compare_header(rsp_data);
            next_wait = draw_wait(rsp_calm);
         end
         if (next_wait > 0) begin
            rsp_stall <= 1'b1;
            rsp_wait  <= next_wait - 1;
         end else begin
            rsp_stall <= 1'b0;
            rsp_wait  <= 0;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int choice;
      int tags;
      int extra;
      int pattern;
      int cut;
      int proto_pick;
      int long_lens [2];
      logic [15:0] ethertype;
      logic [3:0]  ihl;
      logic [7:0]  proto;

      // Runts: one byte, a cut Ethernet header, a bare one, a cut tag.
      build_frame(0, ETYPE_IPV4, 4'd5, PROTO_UDP, 0, FILL_ONES);
      send_frame(1);
      build_frame(0, ETYPE_IPV4, 4'd5, PROTO_UDP, 0, FILL_RANDOM);
      send_frame(ETH_HDR_BYTES - 1);
      send_frame(ETH_HDR_BYTES);
      build_frame(1, ETYPE_IPV6, 4'd5, PROTO_TCP, 0, FILL_RANDOM);
      send_frame(VLAN_HDR_BYTES - 1);

      // Foreign ethertype and a second tag.
      build_frame(0, ETYPE_LLDP, 4'd5, PROTO_UDP, 20, FILL_RANDOM);
      send_frame(0);
      build_frame(2, ETYPE_IPV4, 4'd5, PROTO_UDP, 0, FILL_RANDOM);
      send_frame(0);

      // IPv4: every transport, widest options, bad header lengths, cut headers.
      build_frame(0, ETYPE_IPV4, 4'd5, PROTO_UDP, 0, FILL_ZERO);
      send_frame(0);
      build_frame(0, ETYPE_IPV4, 4'd5, PROTO_TCP, 4, FILL_ONES);
      send_frame(0);
      build_frame(1, ETYPE_IPV4, 4'd5, PROTO_ICMP, 0, FILL_RANDOM);
      send_frame(0);
      build_frame(0, ETYPE_IPV4, 4'd15, PROTO_TCP, 0, FILL_RANDOM);
      send_frame(0);
      build_frame(0, ETYPE_IPV4, 4'd5, PROTO_GRE, 6, FILL_RANDOM);
      send_frame(0);
      build_frame(0, ETYPE_IPV4, 4'd0, PROTO_UDP, 0, FILL_RANDOM);
      send_frame(0);
      build_frame(1, ETYPE_IPV4, 4'd4, PROTO_TCP, 0, FILL_RANDOM);
      send_frame(0);
      build_frame(0, ETYPE_IPV4, 4'd5, PROTO_UDP, 0, FILL_RANDOM);
      send_frame(ETH_HDR_BYTES + IPV4_MIN_BYTES - 1);
      build_frame(0, ETYPE_IPV4, 4'd6, PROTO_TCP, 0, FILL_RANDOM);
      send_frame(frame_bytes.size() - 1);

      // IPv6: every transport, unknown next header, cut headers.
      build_frame(0, ETYPE_IPV6, 4'd5, PROTO_UDP, 0, FILL_ONES);
      send_frame(0);
      build_frame(1, ETYPE_IPV6, 4'd5, PROTO_TCP, 2, FILL_ZERO);
      send_frame(0);
      build_frame(0, ETYPE_IPV6, 4'd5, PROTO_ICMP, 0, FILL_RANDOM);
      send_frame(0);
      build_frame(0, ETYPE_IPV6, 4'd5, PROTO_ICMPV6, 0, FILL_RANDOM);
      send_frame(0);
      build_frame(0, ETYPE_IPV6, 4'd5, PROTO_UDP, 0, FILL_RANDOM);
      send_frame(ETH_HDR_BYTES + IPV6_HDR_BYTES - 1);
      build_frame(1, ETYPE_IPV6, 4'd5, PROTO_UDP, 0, FILL_RANDOM);
      send_frame(frame_bytes.size() - 1);

      // Frames that reach and pass the saturating byte position.
      long_lens = '{256, 300};
      foreach (long_lens[i]) begin
         build_frame(0, ETYPE_IPV4, 4'd5, PROTO_TCP, long_lens[i] - 54, FILL_RANDOM);
         send_frame(0);
      end

      // Random frames: mostly well formed, some broken, some noise.
      while (outgoing_beats.size() < TOTAL_BEATS) begin
         choice    = $urandom_range(0, 99);
         tags      = ($urandom_range(0, 2) == 0) ? 1 : 0;
         ethertype = $urandom_range(0, 1) ? ETYPE_IPV4 : ETYPE_IPV6;
         ihl       = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
         proto_pick = $urandom_range(0, 9);
         if (proto_pick < 3)
            proto = PROTO_UDP;
         else if (proto_pick < 6)
            proto = PROTO_TCP;
         else if (proto_pick < 8)
            proto = PROTO_ICMP;
         else
            proto = 8'($urandom);
         pattern = ($urandom_range(0, 19) == 0) ? $urandom_range(FILL_ZERO, FILL_ONES)
                                                : FILL_RANDOM;
         extra = $urandom_range(0, 6);
         cut   = 0;
         if (choice >= 72 && choice < 92) begin
            // Broken frames.
            case ($urandom_range(0, 3))
               0: cut = -1;
               1: begin
                  ethertype = ETYPE_IPV4;
                  ihl = 4'($urandom_range(0, 4));
               end
               2: tags = 2;
               default: ethertype = 16'($urandom);
            endcase
         end else if (choice >= 92 && choice < 98) begin
            // Noise behind a random ethertype, cut anywhere.
            ethertype = 16'($urandom);
            tags = 0;
            extra = $urandom_range(0, 26);
            cut = -1;
         end else if (choice >= 98) begin
            extra = $urandom_range(190, 250);
         end
         build_frame(tags, ethertype, ihl, proto, extra, pattern);
         if (cut < 0)
            cut = $urandom_range(1, frame_bytes.size());
         send_frame(cut);
      end
      beats_total = outgoing_beats.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (beats_taken < beats_total) @(posedge clock);
      while (parsed_headers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (header_errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
